// ===== rtl/core/rpi_pkg.sv =====
// Shared constants and types for the ray/parallelogram intersection block.
// Used by rpi_norm and ray_parallelogram_intersect; depends on nothing.
`default_nettype none

package rpi_pkg;

  // Width of one packed coordinate slot and of each ray field
  localparam int SLOT_BITS      = 21;
  // Default number of live coordinate bits inside a slot
  localparam int COORD_BITS_DEF = 21;
  // Unit vector component, signed Q1.20
  localparam int UNIT_W         = 22;
  // Distance along the unit ray, Q.20, saturated at all ones
  localparam int LQ_W           = 36;
  // Reported distance, Q16.16
  localparam int DIST_W         = 32;
  // Threshold register width, Q0.20
  localparam int EPS_W          = 20;
  // Packed vector register width
  localparam int VEC_W          = 3 * SLOT_BITS;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CENTER  = 2'd0,
    REG_EDGE_U  = 2'd1,
    REG_EDGE_V  = 2'd2,
    REG_EPSILON = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpi_norm.sv =====
// Pipelined vector normalizer: scales a signed vector to a unit vector in Q1.20.
// Uses rpi_pkg; carries a side payload with the same latency as the result.
`default_nettype none

module rpi_norm #(
  parameter int IN_W   = 43,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic signed [IN_W-1:0]            a_x,
  input  logic signed [IN_W-1:0]            a_y,
  input  logic signed [IN_W-1:0]            a_z,
  input  logic        [SIDE_W-1:0]          side_in,
  output logic signed [rpi_pkg::UNIT_W-1:0] unit_x,
  output logic signed [rpi_pkg::UNIT_W-1:0] unit_y,
  output logic signed [rpi_pkg::UNIT_W-1:0] unit_z,
  output logic                              nonzero,
  output logic        [SIDE_W-1:0]          side_out
);
  import rpi_pkg::*;

  localparam int MAG_W      = 30;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int ROOT_W     = ROOT_STEPS;
  localparam int Q_W        = UNIT_W - 1;
  localparam int K_W        = 5;
  localparam int BL_W       = $clog2(IN_W + 1);
  localparam int LAT        = 7 + ROOT_STEPS + Q_W + 1;

  logic signed [IN_W-1:0] a_in [3];
  assign a_in[0] = a_x;
  assign a_in[1] = a_y;
  assign a_in[2] = a_z;

  // Take magnitudes and signs
  logic [IN_W-1:0] m0 [3];
  logic [2:0]      neg0;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg0[i] <= a_in[i][IN_W-1];
        m0[i]   <= a_in[i][IN_W-1] ? IN_W'(-a_in[i]) : IN_W'(a_in[i]);
      end
    end
  end

  // Find the largest magnitude and the pre-shift that brings it below 2^30
  logic [IN_W-1:0] mx;
  logic [BL_W-1:0] bl;
  logic [BL_W-1:0] sh_c;
  always_comb begin
    mx = m0[0];
    if (m0[1] > mx) mx = m0[1];
    if (m0[2] > mx) mx = m0[2];
    bl = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (mx[b]) bl = BL_W'(b + 1);
    end
    sh_c = (int'(bl) > MAG_W) ? BL_W'(int'(bl) - MAG_W) : '0;
  end

  logic [IN_W-1:0] m1 [3];
  logic [2:0]      neg1;
  logic [BL_W-1:0] sh1;
  logic            nz1;
  always_ff @(posedge clk) begin
    if (en) begin
      m1   <= m0;
      neg1 <= neg0;
      sh1  <= sh_c;
      nz1  <= (mx != '0);
    end
  end

  // Apply the pre-shift
  logic [MAG_W-1:0] m2 [3];
  logic [2:0]       neg2;
  logic             nz2;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m2[i] <= MAG_W'({{MAG_W{1'b0}}, m1[i]} >> sh1);
      end
      neg2 <= neg1;
      nz2  <= nz1;
    end
  end

  // Square each component
  logic [SQ_W-1:0]  sq3 [3];
  logic [MAG_W-1:0] m3  [3];
  logic [2:0]       neg3;
  logic             nz3;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq3[i] <= SQ_W'(m2[i]) * SQ_W'(m2[i]);
      end
      m3   <= m2;
      neg3 <= neg2;
      nz3  <= nz2;
    end
  end

  // Sum the squares
  logic [SUM_W-1:0] s4;
  logic [MAG_W-1:0] m4 [3];
  logic [2:0]       neg4;
  logic             nz4;
  always_ff @(posedge clk) begin
    if (en) begin
      s4   <= SUM_W'(sq3[0]) + SUM_W'(sq3[1]) + SUM_W'(sq3[2]);
      m4   <= m3;
      neg4 <= neg3;
      nz4  <= nz3;
    end
  end

  // Count the pairs of leading zeros that bring the sum into [2^60, 2^62)
  logic [K_W-1:0] k_c;
  always_comb begin
    k_c = '0;
    for (int b = 0; b < SQ_W; b++) begin
      if (s4[b]) k_c = K_W'((SQ_W + 1 - b) >> 1);
    end
    if (s4[SUM_W-1:SQ_W] != '0) k_c = '0;
  end

  logic [SUM_W-1:0] s5;
  logic [K_W-1:0]   k5;
  logic [MAG_W-1:0] m5 [3];
  logic [2:0]       neg5;
  logic             nz5;
  always_ff @(posedge clk) begin
    if (en) begin
      s5   <= s4;
      k5   <= k_c;
      m5   <= m4;
      neg5 <= neg4;
      nz5  <= nz4;
    end
  end

  // Scale the sum and the components; seed the square root
  logic [SUM_W-1:0]  rt_rem [0:ROOT_STEPS];
  logic [SUM_W-1:0]  rt_r   [0:ROOT_STEPS];
  logic [ROOT_W-1:0] rt_a   [0:ROOT_STEPS][3];
  logic [2:0]        rt_neg [0:ROOT_STEPS];
  logic              rt_nz  [0:ROOT_STEPS];
  always_ff @(posedge clk) begin
    if (en) begin
      rt_rem[0] <= SUM_W'(s5 << {k5, 1'b0});
      rt_r[0]   <= '0;
      for (int i = 0; i < 3; i++) begin
        rt_a[0][i] <= ROOT_W'({{ROOT_W{1'b0}}, m5[i]} << k5);
      end
      rt_neg[0] <= neg5;
      rt_nz[0]  <= nz5;
    end
  end

  // Integer square root, one result bit per stage
  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    localparam logic [SUM_W:0] BIT = (SUM_W + 1)'(1) << (SUM_W - 2 - 2 * j);
    logic [SUM_W:0] trial;
    assign trial = {1'b0, rt_r[j]} + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rt_rem[j]} >= trial) begin
          rt_rem[j+1] <= rt_rem[j] - SUM_W'(trial);
          rt_r[j+1]   <= (rt_r[j] >> 1) + SUM_W'(BIT);
        end else begin
          rt_rem[j+1] <= rt_rem[j];
          rt_r[j+1]   <= rt_r[j] >> 1;
        end
        rt_a[j+1]   <= rt_a[j];
        rt_neg[j+1] <= rt_neg[j];
        rt_nz[j+1]  <= rt_nz[j];
      end
    end
  end

  // Divide each scaled component by the root, one quotient bit per stage
  logic [ROOT_W-1:0] dv_rem [0:Q_W-1][3];
  logic [Q_W-1:0]    dv_q   [0:Q_W-1][3];
  logic [ROOT_W-1:0] dv_mg  [0:Q_W-1];
  logic [2:0]        dv_neg [0:Q_W-1];
  logic              dv_nz  [0:Q_W-1];

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic [ROOT_W-1:0] src_rem [3];
    logic [Q_W-1:0]    src_q   [3];
    logic [ROOT_W-1:0] src_mg;
    logic [2:0]        src_neg;
    logic              src_nz;
    logic [ROOT_W:0]   t       [3];

    if (j == 0) begin : g_first
      always_comb begin
        src_rem = rt_a[ROOT_STEPS];
        for (int i = 0; i < 3; i++) begin
          src_q[i] = '0;
          t[i]     = {1'b0, src_rem[i]};
        end
        src_mg  = rt_r[ROOT_STEPS][ROOT_W-1:0];
        src_neg = rt_neg[ROOT_STEPS];
        src_nz  = rt_nz[ROOT_STEPS];
      end
    end else begin : g_next
      always_comb begin
        src_rem = dv_rem[j-1];
        src_q   = dv_q[j-1];
        for (int i = 0; i < 3; i++) begin
          t[i] = {src_rem[i], 1'b0};
        end
        src_mg  = dv_mg[j-1];
        src_neg = dv_neg[j-1];
        src_nz  = dv_nz[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (t[i] >= {1'b0, src_mg}) begin
            dv_rem[j][i] <= ROOT_W'(t[i] - {1'b0, src_mg});
            dv_q[j][i]   <= {src_q[i][Q_W-2:0], 1'b1};
          end else begin
            dv_rem[j][i] <= ROOT_W'(t[i]);
            dv_q[j][i]   <= {src_q[i][Q_W-2:0], 1'b0};
          end
        end
        dv_mg[j]  <= src_mg;
        dv_neg[j] <= src_neg;
        dv_nz[j]  <= src_nz;
      end
    end
  end

  // Restore the signs
  logic signed [UNIT_W-1:0] mag_s [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_s[i] = $signed({1'b0, dv_q[Q_W-1][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_x  <= dv_neg[Q_W-1][0] ? -mag_s[0] : mag_s[0];
      unit_y  <= dv_neg[Q_W-1][1] ? -mag_s[1] : mag_s[1];
      unit_z  <= dv_neg[Q_W-1][2] ? -mag_s[2] : mag_s[2];
      nonzero <= dv_nz[Q_W-1];
    end
  end

  // Carry the side payload alongside
  logic [SIDE_W-1:0] side_pipe [0:LAT-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < LAT; s++) side_pipe[s] <= '0;
    end else if (en) begin
      side_pipe[0] <= side_in;
      for (int s = 1; s < LAT; s++) side_pipe[s] <= side_pipe[s-1];
    end
  end
  assign side_out = side_pipe[LAT-1];

endmodule

`default_nettype wire

// ===== rtl/core/ray_parallelogram_intersect.sv =====
// Ray test against a rectangular area light given by a center and two half-edges.
// Uses rpi_pkg and two rpi_norm normalizers (ray direction and light normal).
//
// Usage:
//   Ray channel: ray_valid/ray_stall with origin_x/y/z and dir_x/y/z, signed Q10.10
//   (low COORD_BITS bits of each field). A request is taken when ray_valid is high
//   and ray_stall is low.
//   Result channel: res_valid/res_stall with hit and distance (Q16.16, 0 on a miss).
//   Config channel: cfg_valid/cfg_ready, cfg_index, cfg_data; cfg_ready is always
//   high. Write registers only while no request is in flight.
//   Pipeline: one entry stage, 60 stages in the normalizers (31-step square root,
//   21-step divide), a 36-step distance divider and the dot, hit point and bounds
//   stages.
//   Throughput: one request per cycle while not stalled; every stage is a register with a valid bit.
//   Stall: when a result is held with res_stall high, the whole pipeline freezes and
//   ray_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset: clears all valid bits and sets center and edges to zero, epsilon to one LSB.
`default_nettype none

module ray_parallelogram_intersect #(
  parameter int COORD_BITS = rpi_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               ray_valid,
  output logic                               ray_stall,
  input  logic signed [rpi_pkg::SLOT_BITS-1:0] origin_x,
  input  logic signed [rpi_pkg::SLOT_BITS-1:0] origin_y,
  input  logic signed [rpi_pkg::SLOT_BITS-1:0] origin_z,
  input  logic signed [rpi_pkg::SLOT_BITS-1:0] dir_x,
  input  logic signed [rpi_pkg::SLOT_BITS-1:0] dir_y,
  input  logic signed [rpi_pkg::SLOT_BITS-1:0] dir_z,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic                               hit,
  output logic        [rpi_pkg::DIST_W-1:0]  distance,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [1:0]                  cfg_index,
  input  logic        [rpi_pkg::VEC_W-1:0]   cfg_data
);
  import rpi_pkg::*;

  localparam int N_W    = 2 * COORD_BITS + 1;
  localparam int REL_W  = COORD_BITS + 1;
  localparam int PD_W   = 2 * UNIT_W;
  localparam int PQ_W   = REL_W + UNIT_W;
  localparam int DQ_W   = (COORD_BITS + 23 > PD_W) ? COORD_BITS + 23 : PD_W;
  localparam int FRAC   = 30;
  localparam int SAT_SH = LQ_W - FRAC;
  localparam int PLO_W  = UNIT_W + 33;
  localparam int HI_W   = LQ_W - 32;
  localparam int PHI_W  = UNIT_W + HI_W + 1;
  localparam int C40_W  = UNIT_W + LQ_W + 2;
  localparam int HP_W   = C40_W - 20;
  localparam int PE_W   = COORD_BITS + HP_W;
  localparam int SU_W   = PE_W + 2;
  localparam int EE_W   = 2 * COORD_BITS + 2;
  localparam int SIDE_W = 3 * COORD_BITS;

  // Configuration registers
  logic [VEC_W-1:0] reg_center;
  logic [VEC_W-1:0] reg_edge_u;
  logic [VEC_W-1:0] reg_edge_v;
  logic [EPS_W-1:0] reg_epsilon;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_center  <= '0;
      reg_edge_u  <= '0;
      reg_edge_v  <= '0;
      reg_epsilon <= EPS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER:  reg_center  <= cfg_data;
        REG_EDGE_U:  reg_edge_u  <= cfg_data;
        REG_EDGE_V:  reg_edge_v  <= cfg_data;
        REG_EPSILON: reg_epsilon <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the light vectors
  logic signed [COORD_BITS-1:0] cen [3];
  logic signed [COORD_BITS-1:0] eu  [3];
  logic signed [COORD_BITS-1:0] ev  [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cen[i] = $signed(reg_center[SLOT_BITS*i +: COORD_BITS]);
      eu[i]  = $signed(reg_edge_u[SLOT_BITS*i +: COORD_BITS]);
      ev[i]  = $signed(reg_edge_v[SLOT_BITS*i +: COORD_BITS]);
    end
  end

  // Advance every stage unless the result register is held
  logic adv;
  assign adv       = !res_valid || !res_stall;
  assign ray_stall = !adv;

  // Entry stage: register the request and form the light normal
  logic                         e_valid;
  logic signed [COORD_BITS-1:0] e_org [3];
  logic signed [COORD_BITS-1:0] e_dir [3];
  logic signed [N_W-1:0]        e_n   [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= ray_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_org[0] <= $signed(origin_x[COORD_BITS-1:0]);
      e_org[1] <= $signed(origin_y[COORD_BITS-1:0]);
      e_org[2] <= $signed(origin_z[COORD_BITS-1:0]);
      e_dir[0] <= $signed(dir_x[COORD_BITS-1:0]);
      e_dir[1] <= $signed(dir_y[COORD_BITS-1:0]);
      e_dir[2] <= $signed(dir_z[COORD_BITS-1:0]);
      e_n[0]   <= N_W'(eu[1]) * N_W'(ev[2]) - N_W'(eu[2]) * N_W'(ev[1]);
      e_n[1]   <= N_W'(eu[2]) * N_W'(ev[0]) - N_W'(eu[0]) * N_W'(ev[2]);
      e_n[2]   <= N_W'(eu[0]) * N_W'(ev[1]) - N_W'(eu[1]) * N_W'(ev[0]);
    end
  end

  // Normalize the direction (origin rides along) and the normal (valid rides along)
  logic signed [UNIT_W-1:0] ud [3];
  logic signed [UNIT_W-1:0] un [3];
  logic                     nz_d;
  logic                     nz_n;
  logic [SIDE_W-1:0]        org_side;
  logic                     nv_valid;

  rpi_norm #(
    .IN_W  (COORD_BITS),
    .SIDE_W(SIDE_W)
  ) u_norm_dir (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .a_x     (e_dir[0]),
    .a_y     (e_dir[1]),
    .a_z     (e_dir[2]),
    .side_in ({e_org[2], e_org[1], e_org[0]}),
    .unit_x  (ud[0]),
    .unit_y  (ud[1]),
    .unit_z  (ud[2]),
    .nonzero (nz_d),
    .side_out(org_side)
  );

  rpi_norm #(
    .IN_W  (N_W),
    .SIDE_W(1)
  ) u_norm_nrm (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .a_x     (e_n[0]),
    .a_y     (e_n[1]),
    .a_z     (e_n[2]),
    .side_in (e_valid),
    .unit_x  (un[0]),
    .unit_y  (un[1]),
    .unit_z  (un[2]),
    .nonzero (nz_n),
    .side_out(nv_valid)
  );

  logic signed [COORD_BITS-1:0] org [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org[i] = $signed(org_side[COORD_BITS*i +: COORD_BITS]);
    end
  end

  // T1: direction products and center offset
  logic                     t1_valid;
  logic                     t1_miss;
  logic signed [PD_W-1:0]   t1_pd  [3];
  logic signed [REL_W-1:0]  t1_rel [3];
  logic signed [UNIT_W-1:0] t1_ud  [3];
  logic signed [UNIT_W-1:0] t1_un  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else if (adv) begin
      t1_valid <= nv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_miss <= !(nz_d && nz_n);
      for (int i = 0; i < 3; i++) begin
        t1_pd[i]  <= PD_W'(un[i]) * PD_W'(ud[i]);
        t1_rel[i] <= REL_W'(cen[i]) - REL_W'(org[i]);
      end
      t1_ud <= ud;
      t1_un <= un;
    end
  end

  // T2: sum d, form plane offset products
  logic                     t2_valid;
  logic                     t2_miss;
  logic signed [DQ_W-1:0]   t2_d;
  logic signed [PQ_W-1:0]   t2_pq  [3];
  logic signed [REL_W-1:0]  t2_rel [3];
  logic signed [UNIT_W-1:0] t2_ud  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_valid <= 1'b0;
    end else if (adv) begin
      t2_valid <= t1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_miss <= t1_miss;
      t2_d    <= DQ_W'(t1_pd[0]) + DQ_W'(t1_pd[1]) + DQ_W'(t1_pd[2]);
      for (int i = 0; i < 3; i++) begin
        t2_pq[i] <= PQ_W'(t1_rel[i]) * PQ_W'(t1_un[i]);
      end
      t2_rel <= t1_rel;
      t2_ud  <= t1_ud;
    end
  end

  // T3: sum q, reject parallel rays
  logic                     t3_valid;
  logic                     t3_miss;
  logic signed [DQ_W-1:0]   t3_q;
  logic        [DQ_W-1:0]   t3_da;
  logic                     t3_dneg;
  logic signed [REL_W-1:0]  t3_rel [3];
  logic signed [UNIT_W-1:0] t3_ud  [3];
  logic        [DQ_W-1:0]   da_c;

  assign da_c = t2_d[DQ_W-1] ? DQ_W'(-t2_d) : DQ_W'(t2_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      t3_valid <= 1'b0;
    end else if (adv) begin
      t3_valid <= t2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t3_miss <= t2_miss || (t2_d == '0) ||
                 (da_c < (DQ_W'(reg_epsilon) << 20));
      t3_q    <= DQ_W'(t2_pq[0]) + DQ_W'(t2_pq[1]) + DQ_W'(t2_pq[2]);
      t3_da   <= da_c;
      t3_dneg <= t2_d[DQ_W-1];
      t3_rel  <= t2_rel;
      t3_ud   <= t2_ud;
    end
  end

  // T4: take |q|, reject hits behind the origin
  logic                     t4_valid;
  logic                     t4_miss;
  logic        [DQ_W-1:0]   t4_qa;
  logic        [DQ_W-1:0]   t4_da;
  logic signed [REL_W-1:0]  t4_rel [3];
  logic signed [UNIT_W-1:0] t4_ud  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t4_valid <= 1'b0;
    end else if (adv) begin
      t4_valid <= t3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t4_miss <= t3_miss || ((t3_q != '0) && (t3_q[DQ_W-1] != t3_dneg));
      t4_qa   <= t3_q[DQ_W-1] ? DQ_W'(-t3_q) : DQ_W'(t3_q);
      t4_da   <= t3_da;
      t4_rel  <= t3_rel;
      t4_ud   <= t3_ud;
    end
  end

  // T5: detect saturation and seed the distance divider
  logic                     dq_valid [0:LQ_W];
  logic                     dq_miss  [0:LQ_W];
  logic                     dq_sat   [0:LQ_W];
  logic        [DQ_W-1:0]   dq_rem   [0:LQ_W];
  logic        [LQ_W-1:0]   dq_q     [0:LQ_W];
  logic        [DQ_W-1:0]   dq_qa    [0:LQ_W];
  logic        [DQ_W-1:0]   dq_da    [0:LQ_W];
  logic signed [REL_W-1:0]  dq_rel   [0:LQ_W][3];
  logic signed [UNIT_W-1:0] dq_ud    [0:LQ_W][3];
  logic                     sat_c;

  assign sat_c = {{SAT_SH{1'b0}}, t4_qa} >= ({{SAT_SH{1'b0}}, t4_da} << SAT_SH);

  always_ff @(posedge clk) begin
    if (rst) begin
      dq_valid[0] <= 1'b0;
    end else if (adv) begin
      dq_valid[0] <= t4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dq_miss[0] <= t4_miss;
      dq_sat[0]  <= sat_c;
      dq_rem[0]  <= sat_c ? '0 : (t4_qa >> SAT_SH);
      dq_q[0]    <= '0;
      dq_qa[0]   <= t4_qa;
      dq_da[0]   <= t4_da;
      dq_rel[0]  <= t4_rel;
      dq_ud[0]   <= t4_ud;
    end
  end

  // Distance divider: |q| * 2^30 / |d|, one quotient bit per stage
  for (genvar j = 0; j < LQ_W; j++) begin : g_ldiv
    localparam int BP = LQ_W - 1 - j;
    logic            nbit;
    logic [DQ_W:0]   t;

    if (BP >= FRAC) begin : g_num
      assign nbit = dq_qa[j][BP-FRAC];
    end else begin : g_zero
      assign nbit = 1'b0;
    end
    assign t = {dq_rem[j], nbit};

    always_ff @(posedge clk) begin
      if (rst) begin
        dq_valid[j+1] <= 1'b0;
      end else if (adv) begin
        dq_valid[j+1] <= dq_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (t >= {1'b0, dq_da[j]}) begin
          dq_rem[j+1] <= DQ_W'(t - {1'b0, dq_da[j]});
          dq_q[j+1]   <= {dq_q[j][LQ_W-2:0], 1'b1};
        end else begin
          dq_rem[j+1] <= DQ_W'(t);
          dq_q[j+1]   <= {dq_q[j][LQ_W-2:0], 1'b0};
        end
        dq_miss[j+1] <= dq_miss[j];
        dq_sat[j+1]  <= dq_sat[j];
        dq_qa[j+1]   <= dq_qa[j];
        dq_da[j+1]   <= dq_da[j];
        dq_rel[j+1]  <= dq_rel[j];
        dq_ud[j+1]   <= dq_ud[j];
      end
    end
  end

  // T6: saturate, reject near hits, split the hit point products
  logic [LQ_W-1:0] lq_c;
  assign lq_c = dq_sat[LQ_W] ? '1 : dq_q[LQ_W];

  logic                    t6_valid;
  logic                    t6_miss;
  logic        [LQ_W-1:0]  t6_lq;
  logic signed [PLO_W-1:0] t6_plo [3];
  logic signed [PHI_W-1:0] t6_phi [3];
  logic signed [REL_W-1:0] t6_rel [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t6_valid <= 1'b0;
    end else if (adv) begin
      t6_valid <= dq_valid[LQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t6_miss <= dq_miss[LQ_W] || (lq_c < LQ_W'(reg_epsilon));
      t6_lq   <= lq_c;
      for (int i = 0; i < 3; i++) begin
        t6_plo[i] <= PLO_W'(dq_ud[LQ_W][i]) * $signed({1'b0, lq_c[31:0]});
        t6_phi[i] <= PHI_W'(dq_ud[LQ_W][i]) * $signed({1'b0, lq_c[LQ_W-1:32]});
      end
      t6_rel <= dq_rel[LQ_W];
    end
  end

  // T7: hit point relative to the center, Q.40
  logic                    t7_valid;
  logic                    t7_miss;
  logic        [LQ_W-1:0]  t7_lq;
  logic signed [C40_W-1:0] t7_c40 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t7_valid <= 1'b0;
    end else if (adv) begin
      t7_valid <= t6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t7_miss <= t6_miss;
      t7_lq   <= t6_lq;
      for (int i = 0; i < 3; i++) begin
        t7_c40[i] <= C40_W'(t6_plo[i]) + (C40_W'(t6_phi[i]) <<< 32) -
                     (C40_W'(t6_rel[i]) <<< FRAC);
      end
    end
  end

  // T8: truncate the hit point toward zero to Q.20
  logic                   t8_valid;
  logic                   t8_miss;
  logic        [LQ_W-1:0] t8_lq;
  logic signed [HP_W-1:0] t8_hp [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t8_valid <= 1'b0;
    end else if (adv) begin
      t8_valid <= t7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t8_miss <= t7_miss;
      t8_lq   <= t7_lq;
      for (int i = 0; i < 3; i++) begin
        if (t7_c40[i][C40_W-1]) begin
          t8_hp[i] <= HP_W'((t7_c40[i] + C40_W'(20'hFFFFF)) >>> 20);
        end else begin
          t8_hp[i] <= HP_W'(t7_c40[i] >>> 20);
        end
      end
    end
  end

  // T9: edge projection products and edge squares
  logic                   t9_valid;
  logic                   t9_miss;
  logic        [LQ_W-1:0] t9_lq;
  logic signed [PE_W-1:0] t9_pu [3];
  logic signed [PE_W-1:0] t9_pv [3];
  logic signed [EE_W-1:0] t9_uu [3];
  logic signed [EE_W-1:0] t9_vv [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t9_valid <= 1'b0;
    end else if (adv) begin
      t9_valid <= t8_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t9_miss <= t8_miss;
      t9_lq   <= t8_lq;
      for (int i = 0; i < 3; i++) begin
        t9_pu[i] <= PE_W'(eu[i]) * PE_W'(t8_hp[i]);
        t9_pv[i] <= PE_W'(ev[i]) * PE_W'(t8_hp[i]);
        t9_uu[i] <= EE_W'(eu[i]) * EE_W'(eu[i]);
        t9_vv[i] <= EE_W'(ev[i]) * EE_W'(ev[i]);
      end
    end
  end

  // T10: sum projections and squared lengths
  logic                   t10_valid;
  logic                   t10_miss;
  logic        [LQ_W-1:0] t10_lq;
  logic signed [SU_W-1:0] t10_su;
  logic signed [SU_W-1:0] t10_sv;
  logic signed [EE_W-1:0] t10_eu;
  logic signed [EE_W-1:0] t10_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      t10_valid <= 1'b0;
    end else if (adv) begin
      t10_valid <= t9_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t10_miss <= t9_miss;
      t10_lq   <= t9_lq;
      t10_su   <= SU_W'(t9_pu[0]) + SU_W'(t9_pu[1]) + SU_W'(t9_pu[2]);
      t10_sv   <= SU_W'(t9_pv[0]) + SU_W'(t9_pv[1]) + SU_W'(t9_pv[2]);
      t10_eu   <= t9_uu[0] + t9_uu[1] + t9_uu[2];
      t10_ev   <= t9_vv[0] + t9_vv[1] + t9_vv[2];
    end
  end

  // T11: bounds check and result register
  logic [SU_W-1:0] abs_u;
  logic [SU_W-1:0] abs_v;
  logic            in_u;
  logic            in_v;
  logic            hit_c;

  assign abs_u = t10_su[SU_W-1] ? SU_W'(-t10_su) : SU_W'(t10_su);
  assign abs_v = t10_sv[SU_W-1] ? SU_W'(-t10_sv) : SU_W'(t10_sv);
  assign in_u  = abs_u <= (SU_W'(t10_eu) << 10);
  assign in_v  = abs_v <= (SU_W'(t10_ev) << 10);
  assign hit_c = !t10_miss && in_u && in_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= t10_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit      <= hit_c;
      distance <= hit_c ? t10_lq[LQ_W-1:LQ_W-DIST_W] : '0;
    end
  end

endmodule

`default_nettype wire
